// ----- rtl/core/fpa_pkg.sv -----
// Shared types and constants for the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int DATA_W = 32;
    localparam int ACT_W  = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_INC      = 4'd4,
        ACT_DEC      = 4'd5,
        ACT_MIN      = 4'd6,
        ACT_MAX      = 4'd7,
        ACT_TO_INT   = 4'd8,
        ACT_FROM_INT = 4'd9
    } t_action;

    localparam logic [DATA_W-1:0] SAT_TOP = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] SAT_BOT = 32'h8000_0000;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] pre;
        logic              ovf;
        logic              dz;
        logic              gt;
        logic              lt;
        logic              eq;
        logic              neg;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
    } t_job;

endpackage

// ----- rtl/core/fpa_front.sv -----
// Front end: accepts a word and classifies it into a job record.
module fpa_front #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                              i_start,
    input  logic                              i_full,
    input  logic [fpa_pkg::ACT_W-1:0]         i_action,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_b,
    output logic                              o_push,
    output fpa_pkg::t_job                     o_job
);

    localparam int W = fpa_pkg::DATA_W;

    logic [W:0]           w_add;
    logic [W:0]           w_sub;
    logic [W:0]           w_inc;
    logic [W:0]           w_dec;
    logic [FRACTION_BITS:0] w_hi;
    logic                 w_fi_ok;

    function automatic logic [W:0] sat_sum(input logic [W:0] s);
        logic [W:0] r;
        if (s[W] != s[W-1]) begin
            r = {1'b1, (s[W] ? fpa_pkg::SAT_BOT : fpa_pkg::SAT_TOP)};
        end else begin
            r = {1'b0, s[W-1:0]};
        end
        return r;
    endfunction

    assign o_push = i_start && !i_full;
    assign w_add = sat_sum({i_operand_a[W-1], i_operand_a} + {i_operand_b[W-1], i_operand_b});
    assign w_sub = sat_sum({i_operand_a[W-1], i_operand_a} - {i_operand_b[W-1], i_operand_b});
    assign w_inc = sat_sum({i_operand_a[W-1], i_operand_a} + (W+1)'(1));
    assign w_dec = sat_sum({i_operand_a[W-1], i_operand_a} - (W+1)'(1));
    assign w_hi = i_operand_a[W-1 -: FRACTION_BITS+1];
    assign w_fi_ok = (w_hi == '0) || (w_hi == '1);

    always_comb begin
        o_job        = '0;
        o_job.action = i_action;
        o_job.gt     = i_operand_a > i_operand_b;
        o_job.lt     = i_operand_a < i_operand_b;
        o_job.eq     = i_operand_a == i_operand_b;
        o_job.neg    = i_operand_a[W-1] ^ i_operand_b[W-1];
        o_job.ma     = i_operand_a[W-1] ? (~i_operand_a + W'(1)) : i_operand_a;
        o_job.mb     = i_operand_b[W-1] ? (~i_operand_b + W'(1)) : i_operand_b;
        unique case (fpa_pkg::t_action'(i_action))
            fpa_pkg::ACT_ADD: {o_job.ovf, o_job.pre} = w_add;
            fpa_pkg::ACT_SUB: {o_job.ovf, o_job.pre} = w_sub;
            fpa_pkg::ACT_INC: {o_job.ovf, o_job.pre} = w_inc;
            fpa_pkg::ACT_DEC: {o_job.ovf, o_job.pre} = w_dec;
            fpa_pkg::ACT_MIN: o_job.pre = o_job.lt ? i_operand_a : i_operand_b;
            fpa_pkg::ACT_MAX: o_job.pre = o_job.gt ? i_operand_a : i_operand_b;
            fpa_pkg::ACT_TO_INT: o_job.pre = i_operand_a >>> FRACTION_BITS;
            fpa_pkg::ACT_FROM_INT: begin
                if (w_fi_ok) begin
                    o_job.pre = i_operand_a << FRACTION_BITS;
                end else begin
                    o_job.ovf = 1'b1;
                    o_job.pre = i_operand_a[W-1] ? fpa_pkg::SAT_BOT : fpa_pkg::SAT_TOP;
                end
            end
            fpa_pkg::ACT_DIV: o_job.dz = (i_operand_b == '0);
            default: o_job.pre = '0;
        endcase
    end

endmodule

// ----- rtl/core/fpa_queue.sv -----
// Short register queue between the front end and the execution pipeline.
module fpa_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fpa_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output fpa_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fpa_pkg::t_job r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_pop;

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= inc_ptr(r_wp);
            end
            if (w_pop) begin
                r_rp <= inc_ptr(r_rp);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(w_pop);
        end
    end

endmodule

// ----- rtl/core/fpa_back.sv -----
// Execution pipeline: multiplier, one-bit-per-stage divider and result select.
module fpa_back #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  fpa_pkg::t_job               i_job,
    output logic                        o_valid,
    output logic [fpa_pkg::DATA_W-1:0]  o_result,
    output logic                        o_a_greater,
    output logic                        o_a_less,
    output logic                        o_a_equal,
    output logic                        o_overflow,
    output logic                        o_divide_by_zero
);

    localparam int W  = fpa_pkg::DATA_W;
    localparam int PW = 2 * W;
    localparam int QW = W + FRACTION_BITS;

    function automatic logic [W:0] clamp_mag(input logic neg, input logic [PW-1:0] mag);
        logic [W:0] r;
        if (neg) begin
            if (mag > PW'(fpa_pkg::SAT_BOT)) begin
                r = {1'b1, fpa_pkg::SAT_BOT};
            end else begin
                r = {1'b0, ~mag[W-1:0] + W'(1)};
            end
        end else begin
            if (mag > PW'(fpa_pkg::SAT_TOP)) begin
                r = {1'b1, fpa_pkg::SAT_TOP};
            end else begin
                r = {1'b0, mag[W-1:0]};
            end
        end
        return r;
    endfunction

    logic          r_a_v;
    fpa_pkg::t_job r_a_job;
    logic [PW-1:0] r_a_prod;

    logic          r_v   [0:QW];
    fpa_pkg::t_job r_job [0:QW];
    logic [W-1:0]  r_rem [0:QW];
    logic [QW-1:0] r_dvd [0:QW];
    logic [QW-1:0] r_quo [0:QW];

    logic [PW-1:0] w_round;
    logic [PW-1:0] w_mq;
    logic [W:0]    w_mres;
    fpa_pkg::t_job n_job0;

    logic          w_rnd;
    logic [QW:0]   w_q1;
    logic [W:0]    w_dres;
    fpa_pkg::t_job w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
        end
        r_a_job  <= i_job;
        r_a_prod <= {{W{1'b0}}, i_job.ma} * {{W{1'b0}}, i_job.mb};
    end

    assign w_round = r_a_prod + (PW'(1) << (FRACTION_BITS - 1));
    assign w_mq    = w_round >> FRACTION_BITS;
    assign w_mres  = clamp_mag(r_a_job.neg && (w_mq != '0), w_mq);

    always_comb begin
        n_job0 = r_a_job;
        if (r_a_job.action == fpa_pkg::ACT_MUL) begin
            n_job0.ovf = w_mres[W];
            n_job0.pre = w_mres[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_a_v;
        end
        r_job[0] <= n_job0;
        r_rem[0] <= '0;
        r_dvd[0] <= {r_a_job.ma, {FRACTION_BITS{1'b0}}};
        r_quo[0] <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [W:0] w_trial;
        logic [W:0] w_diff;
        logic       w_ge;

        assign w_trial = {r_rem[k], r_dvd[k][QW-1]};
        assign w_diff  = w_trial - {1'b0, r_job[k].mb};
        assign w_ge    = w_trial >= {1'b0, r_job[k].mb};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_job[k+1] <= r_job[k];
            r_rem[k+1] <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_dvd[k+1] <= r_dvd[k] << 1;
            r_quo[k+1] <= {r_quo[k][QW-2:0], w_ge};
        end
    end

    assign w_rnd  = {r_rem[QW], 1'b0} >= {1'b0, r_job[QW].mb};
    assign w_q1   = {1'b0, r_quo[QW]} + (QW+1)'(w_rnd);
    assign w_dres = clamp_mag(r_job[QW].neg && (w_q1 != '0), PW'(w_q1));

    always_comb begin
        w_fin = r_job[QW];
        if (r_job[QW].action == fpa_pkg::ACT_DIV) begin
            if (r_job[QW].dz) begin
                w_fin.pre = '0;
                w_fin.ovf = 1'b0;
            end else begin
                w_fin.pre = w_dres[W-1:0];
                w_fin.ovf = w_dres[W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[QW];
        end
        o_result         <= w_fin.pre;
        o_a_greater      <= w_fin.gt;
        o_a_less         <= w_fin.lt;
        o_a_equal        <= w_fin.eq;
        o_overflow       <= w_fin.ovf;
        o_divide_by_zero <= w_fin.dz;
    end

endmodule

// ----- rtl/core/fixed_point_alu_q24_8_top.sv -----
// Top level of the Q24.8 fixed-point ALU.
//
//  Channel  | Handshake                  | Words
//  ---------+----------------------------+-------------------------------------------
//  input    | start high and busy low    | i_action, i_operand_a, i_operand_b
//  result   | o_valid strobe, one cycle  | o_result, compare, overflow, div-by-zero
//
// One word is accepted per cycle while busy is low; each accepted word yields one result strobe.
// The divider resolves one quotient bit per stage.
// Reset is synchronous and clears the queue and all valid bits.
// The receiver cannot stall; busy rises only if the queue is full.
module fixed_point_alu_q24_8_top #(
    parameter int FRACTION_BITS = 8,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fpa_pkg::ACT_W-1:0]         i_action,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_b,
    output logic                              o_valid,
    output logic signed [fpa_pkg::DATA_W-1:0] o_result,
    output logic                              o_a_greater,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_overflow,
    output logic                              o_divide_by_zero
);

    logic          w_full;
    logic          w_push;
    fpa_pkg::t_job w_fjob;
    logic          w_qv;
    fpa_pkg::t_job w_qjob;

    assign busy = w_full;

    fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_start     (start),
        .i_full      (w_full),
        .i_action    (i_action),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_push      (w_push),
        .o_job       (w_fjob)
    );

    fpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .o_valid (w_qv),
        .o_job   (w_qjob)
    );

    fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_qv),
        .i_job            (w_qjob),
        .o_valid          (o_valid),
        .o_result         (o_result),
        .o_a_greater      (o_a_greater),
        .o_a_less         (o_a_less),
        .o_a_equal        (o_a_equal),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

// ----- rtl/core/fpa_chk.sv -----
// Port-level checker for the fixed-point ALU and its bind statement.
module fpa_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic [fpa_pkg::DATA_W-1:0] o_result,
    input logic                       o_a_greater,
    input logic                       o_a_less,
    input logic                       o_a_equal,
    input logic                       o_overflow,
    input logic                       o_divide_by_zero
);

    a_one_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_greater, o_a_less, o_a_equal}))
        else $error("Compare flags are not exclusive.");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result == '0 && !o_overflow))
        else $error("Divide by zero word is not zero.");

    a_dz_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> !o_a_equal || !o_a_less)
        else $error("Divide by zero flags are inconsistent.");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_result == fpa_pkg::SAT_TOP || o_result == fpa_pkg::SAT_BOT))
        else $error("Overflow word is not saturated.");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Result strobe after reset.");

endmodule

bind fixed_point_alu_q24_8_top fpa_chk u_fpa_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .o_result         (o_result),
    .o_a_greater      (o_a_greater),
    .o_a_less         (o_a_less),
    .o_a_equal        (o_a_equal),
    .o_overflow       (o_overflow),
    .o_divide_by_zero (o_divide_by_zero)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU: directed table, then random words.
module tb_top;

    localparam int FRAC       = 8;
    localparam int LATENCY    = 35 + FRAC;
    localparam int DOG_LIMIT  = 20000;
    localparam int N_RANDOM   = 1100;

    typedef struct {
        logic [fpa_pkg::ACT_W-1:0]  action;
        logic [fpa_pkg::DATA_W-1:0] a;
        logic [fpa_pkg::DATA_W-1:0] b;
    } t_cmd;

    typedef struct {
        logic [fpa_pkg::DATA_W-1:0] result;
        logic                       gt;
        logic                       lt;
        logic                       eq;
        logic                       ovf;
        logic                       dz;
    } t_res;

    typedef struct {
        t_cmd cmd;
        bit   typed;
        t_res res;
    } t_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [fpa_pkg::ACT_W-1:0]         i_action;
    logic signed [fpa_pkg::DATA_W-1:0] i_operand_a;
    logic signed [fpa_pkg::DATA_W-1:0] i_operand_b;
    logic                              o_valid;
    logic signed [fpa_pkg::DATA_W-1:0] o_result;
    logic                              o_a_greater;
    logic                              o_a_less;
    logic                              o_a_equal;
    logic                              o_overflow;
    logic                              o_divide_by_zero;

    t_res   pending_results[$];
    t_row   rows[$];
    int     errors;
    int     idle_cycles;
    bit     accepted_now;

    fixed_point_alu_q24_8_top #(.FRACTION_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .o_result(o_result), .o_a_greater(o_a_greater),
        .o_a_less(o_a_less), .o_a_equal(o_a_equal), .o_overflow(o_overflow),
        .o_divide_by_zero(o_divide_by_zero)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [fpa_pkg::DATA_W-1:0] saturate(input logic signed [65:0] v,
                                                            output logic ovf);
        ovf = 1'b0;
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            return fpa_pkg::SAT_TOP;
        end
        if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            return fpa_pkg::SAT_BOT;
        end
        return v[fpa_pkg::DATA_W-1:0];
    endfunction

    function automatic t_res alu_predict(input t_cmd c);
        t_res r;
        logic signed [65:0] sa, sb, sv;
        logic [65:0] ma, mb, p, q, rem;
        logic neg;
        sa = {{34{c.a[31]}}, c.a};
        sb = {{34{c.b[31]}}, c.b};
        ma = sa < 0 ? -sa : sa;
        mb = sb < 0 ? -sb : sb;
        neg = (sa < 0) != (sb < 0);
        r.gt = sa > sb;
        r.lt = sa < sb;
        r.eq = sa == sb;
        r.ovf = 1'b0;
        r.dz = 1'b0;
        r.result = '0;
        case (c.action)
            fpa_pkg::ACT_ADD: r.result = saturate(sa + sb, r.ovf);
            fpa_pkg::ACT_SUB: r.result = saturate(sa - sb, r.ovf);
            fpa_pkg::ACT_MUL: begin
                p = ma * mb;
                q = (p + (66'd1 << (FRAC - 1))) >> FRAC;
                sv = (neg && q != 0) ? -$signed(q) : $signed(q);
                r.result = saturate(sv, r.ovf);
            end
            fpa_pkg::ACT_DIV: begin
                if (sb == 0) begin
                    r.dz = 1'b1;
                end else begin
                    p = ma << FRAC;
                    q = p / mb;
                    rem = p % mb;
                    if (rem >= mb - rem) q = q + 1;
                    sv = (neg && q != 0) ? -$signed(q) : $signed(q);
                    r.result = saturate(sv, r.ovf);
                end
            end
            fpa_pkg::ACT_INC: r.result = saturate(sa + 1, r.ovf);
            fpa_pkg::ACT_DEC: r.result = saturate(sa - 1, r.ovf);
            fpa_pkg::ACT_MIN: r.result = (sa < sb) ? c.a : c.b;
            fpa_pkg::ACT_MAX: r.result = (sa > sb) ? c.a : c.b;
            fpa_pkg::ACT_TO_INT: r.result = $signed(c.a) >>> FRAC;
            fpa_pkg::ACT_FROM_INT: r.result = saturate(sa * (66'sd1 <<< FRAC), r.ovf);
            default: r.result = '0;
        endcase
        return r;
    endfunction

    function automatic logic [fpa_pkg::DATA_W-1:0] random_operand();
        case ($urandom_range(0, 7))
            0: return fpa_pkg::SAT_TOP - $urandom_range(0, 3);
            1: return fpa_pkg::SAT_BOT + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return ($urandom_range(0, 4000) - 2000) <<< FRAC;
            4: return $signed($urandom_range(0, 20'hfffff)) - 20'sh80000;
            5: return $signed($urandom_range(0, 16'hffff)) - 16'sh8000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input fpa_pkg::t_action act, input logic [31:0] a,
                           input logic [31:0] b, input bit typed, input logic [31:0] res,
                           input logic [4:0] flags);
        t_row row;
        row.cmd.action = act;
        row.cmd.a = a;
        row.cmd.b = b;
        row.typed = typed;
        row.res.result = res;
        {row.res.gt, row.res.lt, row.res.eq, row.res.ovf, row.res.dz} = flags;
        rows.push_back(row);
    endtask

    task automatic issue_word(input t_cmd c, input bit typed, input t_res expected);
        start <= 1'b1;
        i_action <= c.action;
        i_operand_a <= c.a;
        i_operand_b <= c.b;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(typed ? expected : alu_predict(c));
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        i_action <= fpa_pkg::ACT_W'($urandom);
        i_operand_a <= $urandom;
        i_operand_b <= $urandom;
        repeat (cycles) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        accepted_now = 1'b0;
        if (i_rst_n && start && !busy) accepted_now = 1'b1;
        if (i_rst_n && o_valid) begin
            accepted_now = 1'b1;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, actual result %h", $time, o_result);
                errors++;
            end else begin
                t_res e;
                e = pending_results.pop_front();
                if (o_result !== e.result || o_a_greater !== e.gt || o_a_less !== e.lt ||
                    o_a_equal !== e.eq || o_overflow !== e.ovf ||
                    o_divide_by_zero !== e.dz) begin
                    $display("%0t: expected %h gt%b lt%b eq%b ovf%b dz%b, actual %h gt%b lt%b eq%b ovf%b dz%b",
                             $time, e.result, e.gt, e.lt, e.eq, e.ovf, e.dz,
                             o_result, o_a_greater, o_a_less, o_a_equal, o_overflow,
                             o_divide_by_zero);
                    errors++;
                end
            end
        end
        idle_cycles = accepted_now ? 0 : idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT) begin
            $display("fixed_point_alu_q24_8_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        t_res none;
        int burst;
        errors = 0;
        idle_cycles = 0;
        none = '{default: '0};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = '0;
        i_operand_a = '0;
        i_operand_b = '0;

        add_row(fpa_pkg::ACT_ADD, 32'h7fffffff, 32'h00000001, 1, 32'h7fffffff, 5'b10010);
        add_row(fpa_pkg::ACT_ADD, 32'h80000000, 32'hffffffff, 1, 32'h80000000, 5'b01010);
        add_row(fpa_pkg::ACT_SUB, 32'h80000000, 32'h00000001, 1, 32'h80000000, 5'b01010);
        add_row(fpa_pkg::ACT_SUB, 32'h7fffffff, 32'hffffffff, 1, 32'h7fffffff, 5'b10010);
        add_row(fpa_pkg::ACT_MUL, 32'h00000180, 32'hfffffe80, 0, 0, 0);
        add_row(fpa_pkg::ACT_MUL, 32'h7fffffff, 32'h7fffffff, 1, 32'h7fffffff, 5'b00110);
        add_row(fpa_pkg::ACT_MUL, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, 5'b01010);
        add_row(fpa_pkg::ACT_MUL, 32'h00000001, 32'hffffff80, 0, 0, 0);
        add_row(fpa_pkg::ACT_DIV, 32'h00000100, 32'h00000000, 1, 32'h00000000, 5'b10001);
        add_row(fpa_pkg::ACT_DIV, 32'h00000000, 32'h00000000, 1, 32'h00000000, 5'b00101);
        add_row(fpa_pkg::ACT_DIV, 32'h80000000, 32'h00000001, 1, 32'h80000000, 5'b01010);
        add_row(fpa_pkg::ACT_DIV, 32'h00000100, 32'hfffffd00, 0, 0, 0);
        add_row(fpa_pkg::ACT_DIV, 32'h80000000, 32'h80000000, 0, 0, 0);
        add_row(fpa_pkg::ACT_INC, 32'h7fffffff, 32'h00000000, 1, 32'h7fffffff, 5'b10010);
        add_row(fpa_pkg::ACT_DEC, 32'h80000000, 32'h00000000, 1, 32'h80000000, 5'b01010);
        add_row(fpa_pkg::ACT_MIN, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, 5'b01000);
        add_row(fpa_pkg::ACT_MIN, 32'h00000005, 32'h00000005, 0, 0, 0);
        add_row(fpa_pkg::ACT_MAX, 32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 5'b01000);
        add_row(fpa_pkg::ACT_TO_INT, 32'hffffff01, 32'h00000000, 1, 32'hffffffff, 5'b01000);
        add_row(fpa_pkg::ACT_TO_INT, 32'h7fffffff, 32'h00000000, 1, 32'h007fffff, 5'b10000);
        add_row(fpa_pkg::ACT_FROM_INT, 32'h00800000, 32'h00000000, 1, 32'h7fffffff, 5'b10010);
        add_row(fpa_pkg::ACT_FROM_INT, 32'hff800000, 32'h00000000, 1, 32'h80000000, 5'b01000);
        add_row(fpa_pkg::ACT_FROM_INT, 32'hfffffffd, 32'h00000000, 0, 0, 0);
        add_row(fpa_pkg::t_action'(4'd15), 32'h00000003, 32'h00000003, 1, 32'h00000000,
                5'b00100);
        add_row(fpa_pkg::t_action'(4'd10), 32'hffffffff, 32'h00000000, 1, 32'h00000000,
                5'b01000);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) issue_word(rows[i].cmd, rows[i].typed, rows[i].res);
        idle_gap(1);
        while (pending_results.size() != 0) @(negedge i_clk);

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                c.action = ($urandom_range(0, 19) == 0)
                           ? fpa_pkg::ACT_W'($urandom_range(10, 15))
                           : fpa_pkg::ACT_W'($urandom_range(0, 9));
                c.a = random_operand();
                c.b = ($urandom_range(0, 15) == 0) ? 32'd0 : random_operand();
                if ($urandom_range(0, 15) == 0) c.b = c.a;
                issue_word(c, 0, none);
            end
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 70));
            if (n == N_RANDOM / 2) begin
                idle_gap(1);
                while (pending_results.size() != 0) @(negedge i_clk);
            end
        end
        idle_gap(1);

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (errors == 0) begin
            $display("fixed_point_alu_q24_8_top: match");
        end else begin
            $display("fixed_point_alu_q24_8_top: mismatch");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_queue.sv
rtl/core/fpa_back.sv
rtl/core/fixed_point_alu_q24_8_top.sv
rtl/core/fpa_chk.sv
tb/tb_top.sv
